// File: hw/rtl/wrp_pkg.sv
package wrp_pkg;

	localparam int unsigned MAX_CHUNKS = 64;
	localparam int unsigned SEEN_W     = $clog2(MAX_CHUNKS + 1);

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam logic [31:0] FIRST_CHUNK = 32'd12;
	localparam logic [31:0] CHDR_LEN    = 32'd8;
	localparam logic [31:0] NEXT_LIMIT  = 32'hFFFF_FFF7;
	localparam logic [31:0] FMT_MIN_LEN = 32'd16;
	localparam logic [31:0] RATE_MIN    = 32'd8000;
	localparam logic [31:0] RATE_MAX    = 32'd96000;
	localparam logic [15:0] FMT_PCM     = 16'd1;
	localparam logic [15:0] BITS_OK     = 16'd16;
	localparam logic [15:0] CHAN_MAX    = 16'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_UNSUPP   = 2'd1;
	localparam logic [1:0] ST_IO_ERR   = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       first_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] channels;
		logic [31:0] sample_rate;
		logic [15:0] sample_width;
		logic [31:0] data_start;
		logic [31:0] data_length;
	} result_t;

endpackage

// File: hw/rtl/wav_riff_header_parser.sv
// channel  direction  handshake                    word
// byte     in         byte_valid / byte_ready      byte_value, first_byte, last_byte
// result   out        result_valid / result_ready  status, channels, sample_rate,
//                                                  sample_width, data_start, data_length
//
// One byte per cycle while no result is held: a byte is registered, then
// parsed from the input register, and any result lands in the output register
// at the end of the cycle in which the byte is parsed.
// arst_n clears the input stage, the parser state and the result valid flag.
// A held result stalls parsing of the registered byte; a new byte is still
// taken in the cycle the result is taken.
module wav_riff_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  byte_value,
	input  logic        first_byte,
	input  logic        last_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  status,
	output logic [15:0] channels,
	output logic [31:0] sample_rate,
	output logic [15:0] sample_width,
	output logic [31:0] data_start,
	output logic [31:0] data_length
);
	import wrp_pkg::*;

	in_word_t in_word;
	in_word_t word_s1;
	logic     valid_s1;
	logic     advance;
	logic     emit;
	result_t  res;
	result_t  res_q;

	assign in_word.byte_value = byte_value;
	assign in_word.first_byte = first_byte;
	assign in_word.last_byte  = last_byte;

	assign advance = valid_s1 && (!result_valid || result_ready);

	wrp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (byte_valid),
		.in_ready (byte_ready),
		.in_word  (in_word),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	wrp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.word   (word_s1),
		.emit   (emit),
		.result (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			if (result_ready) begin
				result_valid <= 1'b0;
			end
			if (advance && emit) begin
				result_valid <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res;
		end
	end

	assign status       = res_q.status;
	assign channels     = res_q.channels;
	assign sample_rate  = res_q.sample_rate;
	assign sample_width = res_q.sample_width;
	assign data_start   = res_q.data_start;
	assign data_length  = res_q.data_length;

endmodule

// File: hw/rtl/wrp_in_stage.sv
module wrp_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  wrp_pkg::in_word_t in_word,
	input  logic              advance,
	output logic              valid_s1,
	output wrp_pkg::in_word_t word_s1
);
	import wrp_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_word;
		end
	end

endmodule

// File: hw/rtl/wrp_core.sv
module wrp_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  wrp_pkg::in_word_t word,
	output logic              emit,
	output wrp_pkg::result_t  result
);
	import wrp_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_CHDR,
		PH_FMT,
		PH_SKIP,
		PH_DONE
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [31:0]         pos_q, pos_d;
	logic [3:0]          cnt_q, cnt_d;
	logic [31:0]         start_q, start_d;
	logic [31:0]         payload_q, payload_d;
	logic [31:0]         tag_q, tag_d;
	logic [31:0]         size_q, size_d;
	logic [SEEN_W-1:0]   seen_q, seen_d;
	logic                fmt_found_q, fmt_found_d;
	logic                data_found_q, data_found_d;
	logic [15:0]         format_q, format_d;
	logic [15:0]         chan_q, chan_d;
	logic [31:0]         rate_q, rate_d;
	logic [15:0]         bits_q, bits_d;
	logic [31:0]         doff_q, doff_d;
	logic [31:0]         dsize_q, dsize_d;
	logic [1:0]          status_d;

	always_comb begin
		logic        end_req;
		logic        finish_req;
		logic [32:0] sum;
		logic [7:0]  b;

		b            = word.byte_value;
		end_req      = 1'b0;
		finish_req   = 1'b0;
		emit         = 1'b0;
		status_d     = ST_OK;
		sum          = '0;

		phase_d      = phase_q;
		pos_d        = pos_q;
		cnt_d        = cnt_q;
		start_d      = start_q;
		payload_d    = payload_q;
		tag_d        = tag_q;
		size_d       = size_q;
		seen_d       = seen_q;
		fmt_found_d  = fmt_found_q;
		data_found_d = data_found_q;
		format_d     = format_q;
		chan_d       = chan_q;
		rate_d       = rate_q;
		bits_d       = bits_q;
		doff_d       = doff_q;
		dsize_d      = dsize_q;

		// restart of a file
		if (word.first_byte) begin
			phase_d      = PH_HEADER;
			pos_d        = '0;
			cnt_d        = '0;
			start_d      = FIRST_CHUNK;
			payload_d    = FIRST_CHUNK + CHDR_LEN;
			tag_d        = '0;
			size_d       = '0;
			seen_d       = '0;
			fmt_found_d  = 1'b0;
			data_found_d = 1'b0;
			format_d     = '0;
			chan_d       = '0;
			rate_d       = '0;
			bits_d       = '0;
			doff_d       = '0;
			dsize_d      = '0;
		end

		if (phase_d != PH_IDLE && phase_d != PH_DONE) begin
			pos_d = pos_d + 32'd1;

			unique case (phase_d)
				PH_HEADER: begin
					if (cnt_d < 4'd4) begin
						tag_d = {tag_d[23:0], b};
					end else if (cnt_d >= 4'd8) begin
						size_d = {size_d[23:0], b};
					end
					if (cnt_d >= 4'd11) begin
						if (tag_d != TAG_RIFF || size_d != TAG_WAVE) begin
							emit     = 1'b1;
							status_d = ST_UNSUPP;
						end else begin
							tag_d   = '0;
							size_d  = '0;
							cnt_d   = '0;
							phase_d = PH_CHDR;
						end
					end else begin
						cnt_d = cnt_d + 4'd1;
					end
				end
				PH_CHDR: begin
					if (cnt_d < 4'd4) begin
						tag_d = {tag_d[23:0], b};
					end else begin
						unique case (cnt_d[1:0])
							2'd0: size_d[7:0]   = b;
							2'd1: size_d[15:8]  = b;
							2'd2: size_d[23:16] = b;
							default: size_d[31:24] = b;
						endcase
					end
					if (cnt_d >= 4'd7) begin
						if (tag_d == TAG_FMT) begin
							if (size_d < FMT_MIN_LEN) begin
								emit     = 1'b1;
								status_d = ST_UNSUPP;
							end else begin
								cnt_d   = '0;
								phase_d = PH_FMT;
							end
						end else if (tag_d == TAG_DATA) begin
							doff_d       = payload_d;
							dsize_d      = size_d;
							data_found_d = 1'b1;
							if (fmt_found_d) begin
								finish_req = 1'b1;
							end else begin
								end_req = 1'b1;
							end
						end else begin
							end_req = 1'b1;
						end
					end else begin
						cnt_d = cnt_d + 4'd1;
					end
				end
				PH_FMT: begin
					unique case (cnt_d)
						4'd0:  format_d        = {8'd0, b};
						4'd1:  format_d[15:8]  = b;
						4'd2:  chan_d          = {8'd0, b};
						4'd3:  chan_d[15:8]    = b;
						4'd4:  rate_d          = {24'd0, b};
						4'd5:  rate_d[15:8]    = b;
						4'd6:  rate_d[23:16]   = b;
						4'd7:  rate_d[31:24]   = b;
						4'd14: bits_d          = {8'd0, b};
						4'd15: bits_d[15:8]    = b;
						default: ;
					endcase
					cnt_d = cnt_d + 4'd1;
					if (cnt_d == 4'd0) begin
						if (format_d != FMT_PCM || bits_d != BITS_OK || chan_d == 16'd0 ||
							chan_d > CHAN_MAX || rate_d < RATE_MIN ||
							rate_d > RATE_MAX) begin
							emit     = 1'b1;
							status_d = ST_UNSUPP;
						end else begin
							fmt_found_d = 1'b1;
							end_req     = 1'b1;
						end
					end
				end
				PH_SKIP: begin
					if (pos_d == start_d) begin
						cnt_d   = '0;
						phase_d = PH_CHDR;
					end
				end
				default: begin
					phase_d = PH_DONE;
				end
			endcase

			// close the chunk: next offset, chunk limit, overflow
			if (end_req) begin
				sum = {1'b0, payload_d} + {1'b0, size_d} + {32'd0, size_d[0]};
				if (sum[32]) begin
					emit     = 1'b1;
					status_d = ST_OVERFLOW;
				end else begin
					seen_d = seen_d + SEEN_W'(1);
					if (seen_d >= SEEN_W'(MAX_CHUNKS)) begin
						finish_req = 1'b1;
					end else if (sum[31:0] > NEXT_LIMIT) begin
						emit     = 1'b1;
						status_d = ST_OVERFLOW;
					end else begin
						start_d   = sum[31:0];
						payload_d = sum[31:0] + CHDR_LEN;
						tag_d     = '0;
						size_d    = '0;
						cnt_d     = '0;
						phase_d   = (pos_d == sum[31:0]) ? PH_CHDR : PH_SKIP;
					end
				end
			end

			if (finish_req) begin
				emit     = 1'b1;
				status_d = (fmt_found_d && data_found_d) ? ST_OK : ST_IO_ERR;
			end

			if (!emit && word.last_byte) begin
				emit     = 1'b1;
				status_d = ST_IO_ERR;
			end

			if (emit) begin
				phase_d = PH_DONE;
			end
		end
	end

	always_comb begin
		result        = '0;
		result.status = status_d;
		if (status_d == ST_OK) begin
			result.channels     = chan_d;
			result.sample_rate  = rate_d;
			result.sample_width = bits_d;
			result.data_start   = doff_d;
			result.data_length  = dsize_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			pos_q        <= '0;
			cnt_q        <= '0;
			start_q      <= FIRST_CHUNK;
			payload_q    <= FIRST_CHUNK + CHDR_LEN;
			tag_q        <= '0;
			size_q       <= '0;
			seen_q       <= '0;
			fmt_found_q  <= 1'b0;
			data_found_q <= 1'b0;
			format_q     <= '0;
			chan_q       <= '0;
			rate_q       <= '0;
			bits_q       <= '0;
			doff_q       <= '0;
			dsize_q      <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			pos_q        <= pos_d;
			cnt_q        <= cnt_d;
			start_q      <= start_d;
			payload_q    <= payload_d;
			tag_q        <= tag_d;
			size_q       <= size_d;
			seen_q       <= seen_d;
			fmt_found_q  <= fmt_found_d;
			data_found_q <= data_found_d;
			format_q     <= format_d;
			chan_q       <= chan_d;
			rate_q       <= rate_d;
			bits_q       <= bits_d;
			doff_q       <= doff_d;
			dsize_q      <= dsize_d;
		end
	end

endmodule
